[sv/msr_pkg.sv]
// Shared types, sizes and helpers for the maximum sub-rectangle sum block.
// Used by msr_alu and max_subrectangle_sum; depends on nothing else.
package msr_pkg;

  // Matrix limits and element width
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ELEM_BITS = 32;

  // Fixed field widths
  localparam int SUM_W  = 64;
  localparam int ELEM_W = 32;
  localparam int CFG_W  = 7;
  localparam int OUT_CW = 7;

  // Derived widths
  localparam int RIDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DIM_MAX   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CRD_W     = $clog2(DIM_MAX + 2);
  localparam int PFX_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = (PFX_DEPTH > 1) ? $clog2(PFX_DEPTH) : 1;

  localparam logic [SUM_W-1:0] ELEM_MASK = (SUM_W'(1) << ELEM_BITS) - SUM_W'(1);

  // Configuration register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_CMP,
    S_LD_WR,
    S_SW_RD,
    S_SW_DIFF,
    S_SW_RUN,
    S_SW_PAIR,
    S_EMIT
  } msr_state_t;

  // Shared adder request and response
  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] c;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] res;
    logic             gt;
    logic             neg;
  } alu_rsp_t;

  // Sign-extend the low ELEM_BITS bits of an item to the sum width
  function automatic logic [SUM_W-1:0] ext_elem(logic [ELEM_W-1:0] raw);
    logic [SUM_W-1:0] v;
    v = SUM_W'(raw) & ELEM_MASK;
    if (v[ELEM_BITS-1]) begin
      v = v | ~ELEM_MASK;
    end
    return v;
  endfunction

  // Clamp a dimension register to 1..hi and return it minus one
  function automatic int dim_m1(logic [CFG_W-1:0] v, int hi);
    int d;
    d = int'(v);
    if (d == 0) begin
      d = 1;
    end
    if (d > hi) begin
      d = hi;
    end
    return d - 1;
  endfunction

  // Prefix store address of (row, column)
  function automatic logic [ADDR_W-1:0] prefix_addr(logic [RIDX_W-1:0] r,
                                                     logic [CIDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage

[sv/msr_alu.sv]
// Shared 64-bit add/subtract unit with a signed compare of the result.
// Depends on msr_pkg for the request and response structs.
module msr_alu (
  input  msr_pkg::alu_req_t req,
  output msr_pkg::alu_rsp_t rsp
);

  logic [msr_pkg::SUM_W-1:0] sum;

  // a + b or a - b, then compare against c
  assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.res = sum;
  assign rsp.neg = sum[msr_pkg::SUM_W-1];
  assign rsp.gt  = $signed(sum) > $signed(req.c);

endmodule

[sv/max_subrectangle_sum.sv]
// Maximum-sum sub-rectangle (2-D Kadane) over a row-major signed matrix.
// Each element is accepted, then compared, then its prefix written through the shared adder.
// After the last element the sweep runs rows*(rows+1)/2 row pairs (skipped when every entry
// is negative), then the emit state loads the result register once it is free.
// Reset (rst_n, synchronous) clears control state; the prefix store needs no clearing pass.
module max_subrectangle_sum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [msr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [msr_pkg::ELEM_W-1:0]  in_element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [msr_pkg::SUM_W-1:0]   out_best_sum,
  output logic [msr_pkg::OUT_CW-1:0]  out_top_row,
  output logic [msr_pkg::OUT_CW-1:0]  out_left_col,
  output logic [msr_pkg::OUT_CW-1:0]  out_bottom_row,
  output logic [msr_pkg::OUT_CW-1:0]  out_right_col
);

  localparam int SW = msr_pkg::SUM_W;
  localparam int RW = msr_pkg::RIDX_W;
  localparam int CW = msr_pkg::CIDX_W;
  localparam int KW = msr_pkg::CRD_W;
  localparam int OW = msr_pkg::OUT_CW;

  msr_pkg::msr_state_t state_r, state_nxt;

  logic [msr_pkg::CFG_W-1:0] row_cnt_r, col_cnt_r;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;

  // Load position and sweep counters
  logic [RW-1:0] r_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] top_r, bot_r;
  logic [CW-1:0] col_r;

  // Datapath registers
  logic [SW-1:0] e_r, best_r, run_sum_r, pair_best_r, diff_r;
  logic [KW-1:0] bt_r, bl_r, bb_r, br_r;
  logic [KW-1:0] run_start_r, from_r, to_r;

  // Prefix store
  logic [SW-1:0] pfx_mem [msr_pkg::PFX_DEPTH];
  logic [SW-1:0] rd_bot_r, rd_top_r;
  logic [msr_pkg::ADDR_W-1:0] addr_a, addr_b, addr_w;

  msr_pkg::alu_req_t alu_req;
  msr_pkg::alu_rsp_t alu_rsp;

  logic in_acc, ld_last, pair_last, col_last, out_free, sweeping;

  // Result register
  logic          out_valid_r;
  logic [SW-1:0] out_sum_r;
  logic [KW-1:0] out_t_r, out_l_r, out_b_r, out_rr_r;

  assign rows_m1 = RW'(msr_pkg::dim_m1(row_cnt_r, msr_pkg::MAX_ROWS));
  assign cols_m1 = CW'(msr_pkg::dim_m1(col_cnt_r, msr_pkg::MAX_COLS));

  assign in_acc    = in_valid && !in_stall;
  assign ld_last   = (r_r == rows_m1) && (c_r == cols_m1);
  assign col_last  = (col_r == cols_m1);
  assign pair_last = (bot_r == rows_m1);
  assign out_free  = !out_valid_r || !out_stall;
  assign sweeping  = (state_r == msr_pkg::S_SW_RD) || (state_r == msr_pkg::S_SW_DIFF) ||
                     (state_r == msr_pkg::S_SW_RUN) || (state_r == msr_pkg::S_SW_PAIR);

  // Store addresses: bottom row on port A, row above on port B
  assign addr_a = msr_pkg::prefix_addr(bot_r, col_r);
  assign addr_b = sweeping ? msr_pkg::prefix_addr(top_r - RW'(1), col_r)
                           : msr_pkg::prefix_addr(r_r - RW'(1), c_r);
  assign addr_w = msr_pkg::prefix_addr(r_r, c_r);

  always_ff @(posedge clk) begin
    if (state_r == msr_pkg::S_LD_WR) begin
      pfx_mem[addr_w] <= alu_rsp.res;
    end
    rd_bot_r <= pfx_mem[addr_a];
    rd_top_r <= pfx_mem[addr_b];
  end

  // Shared adder operand selection
  always_comb begin
    alu_req = '0;
    case (state_r)
      msr_pkg::S_LD_CMP: begin
        alu_req.a = e_r;
        alu_req.c = best_r;
      end
      msr_pkg::S_LD_WR: begin
        alu_req.a = e_r;
        alu_req.b = (r_r != '0) ? rd_top_r : '0;
      end
      msr_pkg::S_SW_DIFF: begin
        alu_req.a   = rd_bot_r;
        alu_req.b   = (top_r != '0) ? rd_top_r : '0;
        alu_req.sub = 1'b1;
      end
      msr_pkg::S_SW_RUN: begin
        alu_req.a = run_sum_r;
        alu_req.b = diff_r;
        alu_req.c = pair_best_r;
      end
      msr_pkg::S_SW_PAIR: begin
        alu_req.a = pair_best_r;
        alu_req.c = best_r;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  msr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Sequencer next state and input stall
  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != msr_pkg::S_IDLE);
    case (state_r)
      msr_pkg::S_IDLE: begin
        if (in_acc) state_nxt = msr_pkg::S_LD_CMP;
      end
      msr_pkg::S_LD_CMP: begin
        state_nxt = msr_pkg::S_LD_WR;
      end
      msr_pkg::S_LD_WR: begin
        if (!ld_last) state_nxt = msr_pkg::S_IDLE;
        else if (best_r[SW-1]) state_nxt = msr_pkg::S_EMIT;
        else state_nxt = msr_pkg::S_SW_RD;
      end
      msr_pkg::S_SW_RD: begin
        state_nxt = msr_pkg::S_SW_DIFF;
      end
      msr_pkg::S_SW_DIFF: begin
        state_nxt = msr_pkg::S_SW_RUN;
      end
      msr_pkg::S_SW_RUN: begin
        state_nxt = col_last ? msr_pkg::S_SW_PAIR : msr_pkg::S_SW_RD;
      end
      msr_pkg::S_SW_PAIR: begin
        state_nxt = (pair_last && (top_r == rows_m1)) ? msr_pkg::S_EMIT
                                                       : msr_pkg::S_SW_RD;
      end
      msr_pkg::S_EMIT: begin
        if (out_free) state_nxt = msr_pkg::S_IDLE;
      end
      default: begin
        state_nxt = msr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and load position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= msr_pkg::CFG_W'(1);
      col_cnt_r <= msr_pkg::CFG_W'(1);
      r_r       <= '0;
      c_r       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == msr_pkg::REG_ROW_COUNT) row_cnt_r <= cfg_wdata;
      if (cfg_index == msr_pkg::REG_COL_COUNT) col_cnt_r <= cfg_wdata;
      r_r <= '0;
      c_r <= '0;
    end else if (state_r == msr_pkg::S_LD_WR) begin
      if (c_r == cols_m1) begin
        c_r <= '0;
        r_r <= (r_r == rows_m1) ? '0 : r_r + RW'(1);
      end else begin
        c_r <= c_r + CW'(1);
      end
    end
  end

  // Best tracking, Kadane scratch and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      bt_r   <= KW'(1);
      bl_r   <= KW'(1);
      bb_r   <= KW'(1);
      br_r   <= KW'(1);
      top_r  <= '0;
      bot_r  <= '0;
      col_r  <= '0;
    end else begin
      case (state_r)
        msr_pkg::S_IDLE: begin
          if (in_acc) e_r <= msr_pkg::ext_elem(in_element);
        end
        msr_pkg::S_LD_CMP: begin
          if ((r_r == '0) && (c_r == '0)) begin
            best_r <= e_r;
            bt_r   <= KW'(1);
            bl_r   <= KW'(1);
            bb_r   <= KW'(1);
            br_r   <= KW'(1);
          end else if (alu_rsp.gt) begin
            best_r <= e_r;
            bt_r   <= KW'(r_r) + KW'(1);
            bl_r   <= KW'(c_r) + KW'(1);
            bb_r   <= KW'(r_r) + KW'(1);
            br_r   <= KW'(c_r) + KW'(1);
          end
        end
        msr_pkg::S_LD_WR: begin
          top_r       <= '0;
          bot_r       <= '0;
          col_r       <= '0;
          run_sum_r   <= '0;
          pair_best_r <= '0;
          run_start_r <= KW'(1);
          from_r      <= KW'(1);
          to_r        <= '0;
        end
        msr_pkg::S_SW_DIFF: begin
          diff_r <= alu_rsp.res;
        end
        msr_pkg::S_SW_RUN: begin
          if (alu_rsp.neg) begin
            run_start_r <= KW'(col_r) + KW'(2);
            run_sum_r   <= '0;
          end else begin
            run_sum_r <= alu_rsp.res;
            if (alu_rsp.gt) begin
              from_r      <= run_start_r;
              pair_best_r <= alu_rsp.res;
              to_r        <= KW'(col_r) + KW'(1);
            end
          end
          if (!col_last) col_r <= col_r + CW'(1);
        end
        msr_pkg::S_SW_PAIR: begin
          if (alu_rsp.gt) begin
            best_r <= pair_best_r;
            bt_r   <= KW'(top_r) + KW'(1);
            bl_r   <= from_r;
            bb_r   <= KW'(bot_r) + KW'(1);
            br_r   <= to_r;
          end
          if (pair_last) begin
            if (top_r != rows_m1) begin
              top_r <= top_r + RW'(1);
              bot_r <= top_r + RW'(1);
            end
          end else begin
            bot_r <= bot_r + RW'(1);
          end
          col_r       <= '0;
          run_sum_r   <= '0;
          pair_best_r <= '0;
          run_start_r <= KW'(1);
          from_r      <= KW'(1);
          to_r        <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register, free while a held result is being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == msr_pkg::S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == msr_pkg::S_EMIT) && out_free) begin
      out_sum_r <= best_r;
      out_t_r   <= bt_r;
      out_l_r   <= bl_r;
      out_b_r   <= bb_r;
      out_rr_r  <= br_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_sum   = out_sum_r;
  assign out_top_row    = OW'(out_t_r);
  assign out_left_col   = OW'(out_l_r);
  assign out_bottom_row = OW'(out_b_r);
  assign out_right_col  = OW'(out_rr_r);

  // A new result only appears after the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == msr_pkg::S_EMIT))
    else $error("result appeared outside emit");

  // The sweep only runs when the best single element is not negative
  a_sweep_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !best_r[SW-1])
    else $error("sweep with negative best");

  // Row pairs keep bottom at or below top
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> (bot_r >= top_r))
    else $error("row pair out of order");

  // A configuration write restarts loading
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> ((r_r == '0) && (c_r == '0)))
    else $error("load position not cleared by config write");

endmodule

[verif/msr_result_check.sv]
// Result checker for max_subrectangle_sum: watches the config, element and result ports,
// predicts every best-rectangle result and compares it field by field.
// Depends on msr_pkg for widths, limits and register indexes.
module msr_result_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [msr_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [msr_pkg::ELEM_W-1:0]        in_element,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [msr_pkg::SUM_W-1:0]         out_best_sum,
  input  logic [msr_pkg::OUT_CW-1:0]        out_top_row,
  input  logic [msr_pkg::OUT_CW-1:0]        out_left_col,
  input  logic [msr_pkg::OUT_CW-1:0]        out_bottom_row,
  input  logic [msr_pkg::OUT_CW-1:0]        out_right_col,
  output int                                fail_count,
  output int                                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [msr_pkg::SUM_W-1:0] best_sum;
    logic [msr_pkg::OUT_CW-1:0]       top_row;
    logic [msr_pkg::OUT_CW-1:0]       left_col;
    logic [msr_pkg::OUT_CW-1:0]       bottom_row;
    logic [msr_pkg::OUT_CW-1:0]       right_col;
  } rect_t;

  rect_t                     pending_rects[$];
  longint                    colsum[msr_pkg::PFX_DEPTH];
  logic [msr_pkg::CFG_W-1:0] rows_reg;
  logic [msr_pkg::CFG_W-1:0] cols_reg;
  int                        loaded;
  longint                    best_val;
  int                        best_top, best_left, best_bot, best_right;
  int                        errs = 0;

  // Register value as used by the block: zero means one, large values saturate
  function automatic int span(logic [msr_pkg::CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  // Kadane over every row pair, top ascending then bottom ascending
  function automatic void sweep_row_pairs(int nr, int nc);
    longint run, pbest, above;
    int from, to, start;
    for (int t = 0; t < nr; t++) begin
      for (int b = t; b < nr; b++) begin
        run   = 0;
        pbest = 0;
        start = 1;
        from  = 1;
        to    = 0;
        for (int c = 0; c < nc; c++) begin
          above = (t != 0) ? colsum[(t - 1) * msr_pkg::MAX_COLS + c] : 64'sd0;
          run += colsum[b * msr_pkg::MAX_COLS + c] - above;
          if (run < 0) begin
            start = c + 2;
            run   = 0;
          end else if (run > pbest) begin
            from  = start;
            pbest = run;
            to    = c + 1;
          end
        end
        // only a strictly larger rectangle replaces the best
        if (pbest > best_val) begin
          best_val   = pbest;
          best_top   = t + 1;
          best_left  = from;
          best_bot   = b + 1;
          best_right = to;
        end
      end
    end
  endfunction

  // One accepted element: prefix update, single-element best, sweep on the last one
  function automatic void absorb_element(logic [msr_pkg::ELEM_W-1:0] raw);
    int nr, nc, total, r, c;
    longint e;
    rect_t res;
    nr    = span(rows_reg, msr_pkg::MAX_ROWS);
    nc    = span(cols_reg, msr_pkg::MAX_COLS);
    total = nr * nc;
    e     = (longint'(raw) << (msr_pkg::SUM_W - msr_pkg::ELEM_BITS))
            >>> (msr_pkg::SUM_W - msr_pkg::ELEM_BITS);
    if (loaded >= total) loaded = 0;
    r = loaded / nc;
    c = loaded % nc;
    // first element seeds the best; later ones must be strictly greater
    if (loaded == 0 || e > best_val) begin
      best_val   = e;
      best_top   = r + 1;
      best_left  = c + 1;
      best_bot   = r + 1;
      best_right = c + 1;
    end
    colsum[r * msr_pkg::MAX_COLS + c] =
      e + ((r != 0) ? colsum[(r - 1) * msr_pkg::MAX_COLS + c] : 64'sd0);
    loaded++;
    if (loaded < total) return;
    loaded = 0;
    // all-negative matrix: the single largest element stands
    if (best_val >= 0) sweep_row_pairs(nr, nc);
    res.best_sum   = best_val;
    res.top_row    = msr_pkg::OUT_CW'(best_top);
    res.left_col   = msr_pkg::OUT_CW'(best_left);
    res.bottom_row = msr_pkg::OUT_CW'(best_bot);
    res.right_col  = msr_pkg::OUT_CW'(best_right);
    pending_rects.push_back(res);
  endfunction

  function automatic int field_mismatch(string label,
                                        logic signed [msr_pkg::SUM_W-1:0] want,
                                        logic signed [msr_pkg::SUM_W-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
    return 1;
  endfunction

  // Compare an accepted result against the oldest expectation
  function automatic void check_result();
    rect_t want;
    if (pending_rects.size() == 0) begin
      $display("%0t: unexpected result, expected none actual sum %0d", $time,
               $signed(out_best_sum));
      errs++;
      return;
    end
    want = pending_rects.pop_front();
    errs += field_mismatch("best_sum", want.best_sum, $signed(out_best_sum));
    errs += field_mismatch("top_row", want.top_row, out_top_row);
    errs += field_mismatch("left_col", want.left_col, out_left_col);
    errs += field_mismatch("bottom_row", want.bottom_row, out_bottom_row);
    errs += field_mismatch("right_col", want.right_col, out_right_col);
  endfunction

  // Results first: one finishing at this edge cannot belong to an item taken now
  always @(posedge clk) begin
    if (!rst_n) begin
      pending_rects.delete();
      rows_reg   = msr_pkg::CFG_W'(1);
      cols_reg   = msr_pkg::CFG_W'(1);
      loaded     = 0;
      best_val   = 0;
      best_top   = 1;
      best_left  = 1;
      best_bot   = 1;
      best_right = 1;
    end else begin
      if (out_valid && !out_stall) check_result();
      // any register write restarts loading
      if (cfg_we) begin
        case (cfg_index)
          msr_pkg::REG_ROW_COUNT: rows_reg = cfg_wdata;
          msr_pkg::REG_COL_COUNT: cols_reg = cfg_wdata;
          default: begin
          end
        endcase
        loaded = 0;
      end
      if (in_valid && !in_stall) absorb_element(in_element);
    end
    fail_count    <= errs;
    pending_count <= pending_rects.size();
  end

endmodule

[verif/tb_top.sv]
// Top-level bench for max_subrectangle_sum: clock, reset, matrix stimulus and verdict.
// Depends on msr_pkg, the block and msr_result_check, which predicts and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {GEN_MIX, GEN_WIDE, GEN_NEG, GEN_TIES, GEN_SPARSE} fill_t;

  localparam int     SETTLE       = 16;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     RANDOM_ITEMS = 750;
  localparam longint CYCLE_LIMIT  = 2000000;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               cfg_we     = 1'b0;
  logic                               cfg_index  = msr_pkg::REG_ROW_COUNT;
  logic [msr_pkg::CFG_W-1:0]          cfg_wdata  = '0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic [msr_pkg::ELEM_W-1:0]         in_element = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic [msr_pkg::SUM_W-1:0]          out_best_sum;
  logic [msr_pkg::OUT_CW-1:0]         out_top_row, out_left_col, out_bottom_row;
  logic [msr_pkg::OUT_CW-1:0]         out_right_col;

  int     fail_count;
  int     pending_count;
  longint cycles     = 0;
  int     items_sent = 0;
  int     phase;
  logic   calm       = 1'b0;
  logic   hold_req   = 1'b0;
  logic   hold_done  = 1'b0;
  int     hold_left  = 0;

  max_subrectangle_sum dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_element,
    .out_valid, .out_stall, .out_best_sum,
    .out_top_row, .out_left_col, .out_bottom_row, .out_right_col
  );

  msr_result_check chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_element,
    .out_valid, .out_stall, .out_best_sum,
    .out_top_row, .out_left_col, .out_bottom_row, .out_right_col,
    .fail_count, .pending_count
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end
  end

  function automatic int eff_dim(logic [msr_pkg::CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  function automatic logic [msr_pkg::ELEM_W-1:0] make_elem(fill_t mode);
    case (mode)
      GEN_MIX:  return msr_pkg::ELEM_W'($urandom_range(0, 200)) - msr_pkg::ELEM_W'(100);
      GEN_WIDE: return msr_pkg::ELEM_W'($urandom);
      GEN_NEG:  return {1'b1, (msr_pkg::ELEM_W-1)'($urandom)};
      GEN_TIES: return msr_pkg::ELEM_W'($urandom_range(0, 6)) - msr_pkg::ELEM_W'(3);
      default: begin
        // mostly small negatives with the odd positive
        if ($urandom_range(0, 9) == 0) return msr_pkg::ELEM_W'($urandom_range(0, 50));
        return msr_pkg::ELEM_W'(0) - msr_pkg::ELEM_W'($urandom_range(1, 50));
      end
    endcase
  endfunction

  // Offer one item, hold it until taken, then maybe idle a few cycles
  task automatic send_item(input logic [msr_pkg::ELEM_W-1:0] value);
    in_valid   <= 1'b1;
    in_element <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait until every expected result is in and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_dims(input logic [msr_pkg::CFG_W-1:0] rows,
                          input logic [msr_pkg::CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= msr_pkg::REG_ROW_COUNT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= msr_pkg::REG_COL_COUNT;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One setting: whole matrices, optionally a dropped partial one at the end
  task automatic run_matrices(input logic [msr_pkg::CFG_W-1:0] rows,
                              input logic [msr_pkg::CFG_W-1:0] cols,
                              input int count, input bit pick_fill, input fill_t fill,
                              input bit tail);
    int n;
    fill_t f;
    set_dims(rows, cols);
    n = eff_dim(rows, msr_pkg::MAX_ROWS) * eff_dim(cols, msr_pkg::MAX_COLS);
    repeat (count) begin
      f = pick_fill ? fill_t'($urandom_range(0, 4)) : fill;
      repeat (n) send_item(make_elem(f));
    end
    if (tail && n > 1) begin
      repeat ($urandom_range(1, n - 1)) send_item(make_elem(GEN_MIX));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero registers read as one: 1x1 matrices, element extremes
    set_dims(msr_pkg::CFG_W'(0), msr_pkg::CFG_W'(0));
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    drain();

    // All entries negative, tied maximum: first one wins
    set_dims(msr_pkg::CFG_W'(2), msr_pkg::CFG_W'(3));
    send_item(-5);
    send_item(-2);
    send_item(-9);
    send_item(-2);
    send_item(-7);
    send_item(-3);
    drain();

    // Partial matrix dropped by a register write, then equal-sum rectangles
    set_dims(msr_pkg::CFG_W'(2), msr_pkg::CFG_W'(2));
    send_item(9);
    send_item(9);
    send_item(9);
    drain();
    set_dims(msr_pkg::CFG_W'(2), msr_pkg::CFG_W'(2));
    send_item(4);
    send_item(-10);
    send_item(-1);
    send_item(4);
    drain();

    // Random part: extreme shapes first, then small random shapes;
    // the wide 2x64 pair runs with no idling on either side
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm <= (phase == 1);
      case (phase)
        0: run_matrices(msr_pkg::CFG_W'(64), msr_pkg::CFG_W'(2), 1, 1'b1, GEN_MIX, 1'b0);
        1: run_matrices(msr_pkg::CFG_W'(2), msr_pkg::CFG_W'(64), 2, 1'b1, GEN_MIX, 1'b0);
        2: run_matrices(msr_pkg::CFG_W'(100), msr_pkg::CFG_W'(1), 1, 1'b1, GEN_MIX, 1'b0);
        3: run_matrices(msr_pkg::CFG_W'(1), msr_pkg::CFG_W'(127), 1, 1'b1, GEN_MIX, 1'b1);
        4: begin
          hold_req <= 1'b1;
          run_matrices(msr_pkg::CFG_W'(1), msr_pkg::CFG_W'(1), 40, 1'b1, GEN_MIX, 1'b0);
        end
        default: run_matrices(msr_pkg::CFG_W'($urandom_range(0, 9)),
                              msr_pkg::CFG_W'($urandom_range(0, 9)),
                              $urandom_range(1, 4), 1'b1, GEN_MIX,
                              $urandom_range(0, 4) == 0);
      endcase
      phase++;
    end
    calm <= 1'b0;

    // Tall all-negative matrix, row register saturated
    run_matrices(msr_pkg::CFG_W'(127), msr_pkg::CFG_W'(2), 1, 1'b0, GEN_NEG, 1'b0);

    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
